[hdl/pat_pkg.sv]
// Package for the peer address table: widths, status codes and operation codes.
`timescale 1ns / 1ps

package pat_pkg;

  // Default table depth
  localparam int ENTRIES_DEF = 16;

  // Field widths
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;

  // Operation codes carried on in_func
  localparam logic FN_FIND = 1'b0;
  localparam logic FN_FREE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND       = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_FREED       = 3'd2,
    ST_FULL        = 3'd3,
    ST_FREE_UNUSED = 3'd4
  } status_t;

endpackage

[hdl/pat_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read: the word is available in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/pat_ctrl.sv]
// Lookup sequencer: valid flags, entry scan over the RAM, insert and free.
`timescale 1ns / 1ps

module pat_ctrl import pat_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1),
  localparam int FS_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W,
  localparam int MEM_W  = IP_W + PORT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [IP_W-1:0]     in_peer_ip,
  input  logic [PORT_W-1:0]   in_peer_port,
  input  logic [SLOT_W-1:0]   in_free_slot,
  // result side
  output logic                out_strobe,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status,
  // entry RAM
  output logic                ram_wr_en,
  output logic [IDX_W-1:0]    ram_wr_addr,
  output logic [MEM_W-1:0]    ram_wr_data,
  output logic                ram_rd_en,
  output logic [IDX_W-1:0]    ram_rd_addr,
  input  logic [MEM_W-1:0]    ram_rd_data
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                cmp_go_r, cmp_go_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IP_W-1:0]     key_ip_r, key_ip_nxt;
  logic [PORT_W-1:0]   key_port_r, key_port_nxt;
  logic                have_free_r, have_free_nxt;
  logic [IDX_W-1:0]    first_free_r, first_free_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic                strobe_r, strobe_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  status_t             status_r, status_nxt;

  logic [FS_W-1:0]     fs_w;
  logic                fs_ok;
  logic [IDX_W-1:0]    fs_idx;
  logic                ent_v;
  logic                ent_hit;
  logic                cmp_last;
  logic                free_any;
  logic [IDX_W-1:0]    free_idx;

  // Free request decode
  assign fs_w   = FS_W'(in_free_slot);
  assign fs_ok  = (fs_w < FS_W'(ENTRIES));
  assign fs_idx = fs_w[IDX_W-1:0];

  // Compare stage: entry read last cycle against the key
  assign ent_v    = valid_r[cmp_idx_r];
  assign ent_hit  = ent_v && (ram_rd_data == {key_ip_r, key_port_r});
  assign cmp_last = (cmp_idx_r == IDX_W'(ENTRIES - 1));
  assign free_any = have_free_r || !ent_v;
  assign free_idx = have_free_r ? first_free_r : cmp_idx_r;

  // RAM hookup
  assign ram_rd_addr = rd_cnt_r[IDX_W-1:0];
  assign ram_wr_addr = free_idx;
  assign ram_wr_data = {key_ip_r, key_port_r};

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_go_nxt     = cmp_go_r;
    cmp_idx_nxt    = cmp_idx_r;
    key_ip_nxt     = key_ip_r;
    key_port_nxt   = key_port_r;
    have_free_nxt  = have_free_r;
    first_free_nxt = first_free_r;
    valid_nxt      = valid_r;
    strobe_nxt     = 1'b0;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    ram_rd_en      = 1'b0;
    ram_wr_en      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FN_FREE) begin
            // free completes at once from the valid flags
            strobe_nxt = 1'b1;
            slot_nxt   = in_free_slot;
            if (fs_ok && valid_r[fs_idx]) begin
              valid_nxt[fs_idx] = 1'b0;
              status_nxt        = ST_FREED;
            end else begin
              status_nxt = ST_FREE_UNUSED;
            end
          end else begin
            state_nxt      = S_SCAN;
            key_ip_nxt     = in_peer_ip;
            key_port_nxt   = in_peer_port;
            rd_cnt_nxt     = '0;
            have_free_nxt  = 1'b0;
            first_free_nxt = '0;
          end
        end
      end

      S_SCAN: begin
        // read stage: one entry per cycle
        if (rd_cnt_r != CNT_W'(ENTRIES)) begin
          ram_rd_en   = 1'b1;
          cmp_go_nxt  = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = CNT_W'(rd_cnt_r + 1'b1);
        end else begin
          cmp_go_nxt = 1'b0;
        end

        // compare stage
        if (cmp_go_r) begin
          if (ent_hit) begin
            state_nxt  = S_IDLE;
            cmp_go_nxt = 1'b0;
            strobe_nxt = 1'b1;
            slot_nxt   = SLOT_W'(cmp_idx_r);
            status_nxt = ST_FOUND;
          end else begin
            // remember the lowest free slot seen so far
            if (!have_free_r && !ent_v) begin
              have_free_nxt  = 1'b1;
              first_free_nxt = cmp_idx_r;
            end
            if (cmp_last) begin
              state_nxt  = S_IDLE;
              cmp_go_nxt = 1'b0;
              strobe_nxt = 1'b1;
              if (free_any) begin
                ram_wr_en           = 1'b1;
                valid_nxt[free_idx] = 1'b1;
                slot_nxt            = SLOT_W'(free_idx);
                status_nxt          = ST_INSERTED;
              end else begin
                slot_nxt   = '0;
                status_nxt = ST_FULL;
              end
            end
          end
        end
      end

      default: begin
        state_nxt  = S_IDLE;
        cmp_go_nxt = 1'b0;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cmp_go_r <= 1'b0;
      valid_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cmp_go_r <= cmp_go_nxt;
      valid_r  <= valid_nxt;
      strobe_r <= strobe_nxt;
    end
    rd_cnt_r     <= rd_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    key_ip_r     <= key_ip_nxt;
    key_port_r   <= key_port_nxt;
    have_free_r  <= have_free_nxt;
    first_free_r <= first_free_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_slot   = slot_r;
  assign out_status = status_r;

  // A find transfer always enters the scan
  a_find_scans: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == FN_FIND) |=> busy)
    else $error("find transfer did not start a scan");

  // A free transfer answers in the next cycle
  a_free_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == FN_FREE) |=> out_strobe)
    else $error("free transfer gave no result");

  // No result is shown while a scan is still running
  a_no_strobe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe during scan");

  // Table full only when every slot is taken
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_FULL) |-> (&valid_r))
    else $error("table full reported with a free slot");

  // An insert claims exactly one slot
  a_insert_claims_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_INSERTED) |->
      ($countones(valid_r) == $countones($past(valid_r)) + 1))
    else $error("insert did not claim exactly one slot");

endmodule

[hdl/peer_address_table.sv]
// Top level of the peer address table: lookup sequencer plus entry RAM.
//
//   channel   ports                                          handshake
//   -------   --------------------------------------------   -----------------------
//   command   in_func, in_peer_ip, in_peer_port, in_free_slot  start high, busy low
//   result    out_slot, out_status                           out_strobe, one cycle
//
// A free's result strobes in the cycle after the transfer.
// A find scans the entry RAM one entry per cycle through its single read port and
// finishes on the first match or, with no match, after the last entry.
// busy is high while a scan runs; a new command is taken the cycle busy drops,
// while the previous result is still on the result ports.
// Synchronous active-low reset clears the valid flags; no clearing pass is needed.
// The receiver cannot stall: each result is taken in the one cycle it is shown.
`timescale 1ns / 1ps

module peer_address_table import pat_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [IP_W-1:0]     in_peer_ip,
  input  logic [PORT_W-1:0]   in_peer_port,
  input  logic [SLOT_W-1:0]   in_free_slot,
  output logic                out_strobe,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int MEM_W = IP_W + PORT_W;

  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [MEM_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [MEM_W-1:0] ram_rd_data;

  // Sequencer
  pat_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_peer_ip   (in_peer_ip),
    .in_peer_port (in_peer_port),
    .in_free_slot (in_free_slot),
    .out_strobe   (out_strobe),
    .out_slot     (out_slot),
    .out_status   (out_status),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  // Entry store: ip and port per slot
  pat_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

[tb/tb.sv]
// Testbench for the peer address table: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps

module tb import pat_pkg::*; ();

  // One command as driven on the input ports
  typedef struct packed {
    logic                func;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
    logic [SLOT_W-1:0]   fslot;
  } peer_cmd_t;

  // One lookup result
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } peer_result_t;

  // Directed row: command plus an optional hand-written expectation
  typedef struct {
    peer_cmd_t    cmd;
    bit           typed;
    peer_result_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_func = FN_FIND;
  logic [IP_W-1:0]     in_peer_ip = '0;
  logic [PORT_W-1:0]   in_peer_port = '0;
  logic [SLOT_W-1:0]   in_free_slot = '0;
  logic                out_strobe;
  logic [SLOT_W-1:0]   out_slot;
  logic [STATUS_W-1:0] out_status;

  // Hand-written expectation travels with the command
  bit           drv_typed = 1'b0;
  peer_result_t drv_expect = '{slot: '0, status: ST_FOUND};

  // Shadow copy of the table, updated at each accepted transfer
  bit                shadow_valid [ENTRIES_DEF];
  logic [IP_W-1:0]   shadow_ip    [ENTRIES_DEF];
  logic [PORT_W-1:0] shadow_port  [ENTRIES_DEF];

  peer_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  int           mismatches = 0;
  int           accepted = 0;
  int           status_seen [5];

  // Peer pool for well-formed random traffic
  logic [IP_W-1:0]   pool_ip   [6];
  logic [PORT_W-1:0] pool_port [4];

  peer_address_table i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_peer_ip   (in_peer_ip),
    .in_peer_port (in_peer_port),
    .in_free_slot (in_free_slot),
    .out_strobe   (out_strobe),
    .out_slot     (out_slot),
    .out_status   (out_status)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Find-or-insert / free against the shadow table
  function automatic peer_result_t resolve_peer(input peer_cmd_t c);
    peer_result_t r;
    bit           have_free;
    int           first_free;
    int           i;
    have_free  = 1'b0;
    first_free = 0;
    if (c.func == FN_FREE) begin
      r.slot = c.fslot;
      if (c.fslot < ENTRIES_DEF && shadow_valid[c.fslot]) begin
        shadow_valid[c.fslot] = 1'b0;
        r.status = ST_FREED;
      end else begin
        r.status = ST_FREE_UNUSED;
      end
      return r;
    end
    for (i = 0; i < ENTRIES_DEF; i++) begin
      if (shadow_valid[i]) begin
        if (shadow_ip[i] == c.ip && shadow_port[i] == c.port) begin
          r.slot   = SLOT_W'(i);
          r.status = ST_FOUND;
          return r;
        end
      end else if (!have_free) begin
        have_free  = 1'b1;
        first_free = i;
      end
    end
    if (!have_free) begin
      r.slot   = '0;
      r.status = ST_FULL;
      return r;
    end
    shadow_valid[first_free] = 1'b1;
    shadow_ip[first_free]    = c.ip;
    shadow_port[first_free]  = c.port;
    r.slot   = SLOT_W'(first_free);
    r.status = ST_INSERTED;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Result check, then expectation for any transfer at this edge
  always @(posedge clk) begin : result_check
    peer_result_t want;
    peer_result_t model;
    peer_cmd_t    cmd;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: slot %0d status %0d",
                                    out_slot, out_status));
        end else begin
          want = pending_results.pop_front();
          if (out_slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", out_slot, want.slot));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (slot %0d)",
                                      out_status, want.status, want.slot));
        end
      end
      if (start && !busy) begin
        cmd   = '{in_func, in_peer_ip, in_peer_port, in_free_slot};
        model = resolve_peer(cmd);
        pending_results.push_back(drv_typed ? drv_expect : model);
        status_seen[model.status] += 1;
        accepted++;
      end
    end
  end

  task automatic add_row(input logic func, input logic [IP_W-1:0] ip,
                         input logic [PORT_W-1:0] port, input logic [SLOT_W-1:0] fs,
                         input bit typed, input logic [SLOT_W-1:0] slot, input status_t st);
    dir_row_t row;
    row.cmd   = '{func, ip, port, fs};
    row.typed = typed;
    row.res   = '{slot, st};
    dir_rows.push_back(row);
  endtask

  // Drive one command and hold it until the transfer; start stays high into the next one
  task automatic issue(input peer_cmd_t c, input bit typed, input peer_result_t r,
                       input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start        <= 1'b1;
    in_func      <= c.func;
    in_peer_ip   <= c.ip;
    in_peer_port <= c.port;
    in_free_slot <= c.fslot;
    drv_typed    <= typed;
    drv_expect   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic new_peer_pool();
    int i;
    for (i = 0; i < 6; i++) pool_ip[i] = $urandom;
    for (i = 0; i < 4; i++) pool_port[i] = PORT_W'($urandom_range(65535));
  endtask

  // Mostly pool peers so entries hit and fill; some fresh noise and random frees
  function automatic peer_cmd_t random_cmd(input int free_pct);
    peer_cmd_t c;
    int        r;
    r       = $urandom_range(99);
    c.func  = FN_FIND;
    c.ip    = pool_ip[$urandom_range(5)];
    c.port  = pool_port[$urandom_range(3)];
    c.fslot = SLOT_W'($urandom_range(15));
    if (r < free_pct) begin
      c.func = FN_FREE;
      c.ip   = $urandom;
      c.port = PORT_W'($urandom_range(65535));
    end else if (r < free_pct + 8) begin
      c.ip   = $urandom;
      c.port = PORT_W'($urandom_range(65535));
    end
    return c;
  endfunction

  // Stimulus
  initial begin
    peer_result_t no_expect;
    int           k;
    int           ph;
    int           n;
    int           idle_pct;
    int           free_pct;
    no_expect = '{'0, ST_FOUND};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, field extremes, partial matches, fill to full, refill
    add_row(FN_FREE, 32'h0,         16'h0,    4'd0,  1, 4'd0,  ST_FREE_UNUSED);
    add_row(FN_FREE, 32'h0,         16'h0,    4'd15, 1, 4'd15, ST_FREE_UNUSED);
    add_row(FN_FIND, 32'h0,         16'h0,    4'd0,  1, 4'd0,  ST_INSERTED);
    add_row(FN_FIND, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 1, 4'd1,  ST_INSERTED);
    add_row(FN_FIND, 32'h0,         16'h0,    4'd0,  1, 4'd0,  ST_FOUND);
    add_row(FN_FIND, 32'h0,         16'hFFFF, 4'd0,  1, 4'd2,  ST_INSERTED);
    add_row(FN_FIND, 32'hFFFF_FFFF, 16'h0,    4'd0,  1, 4'd3,  ST_INSERTED);
    add_row(FN_FREE, 32'h0,         16'h0,    4'd0,  1, 4'd0,  ST_FREED);
    add_row(FN_FREE, 32'hFFFF_FFFF, 16'hFFFF, 4'd0,  1, 4'd0,  ST_FREE_UNUSED);
    add_row(FN_FIND, 32'h0,         16'hFFFF, 4'd0,  1, 4'd2,  ST_FOUND);
    add_row(FN_FIND, 32'h1234_5678, 16'h0001, 4'd0,  1, 4'd0,  ST_INSERTED);
    for (k = 4; k < ENTRIES_DEF; k++)
      add_row(FN_FIND, IP_W'(32'hA500_0000 + k), PORT_W'(16'h1000 + k), 4'd0, 0, 4'd0,
              ST_FOUND);
    add_row(FN_FIND, 32'hC0A8_0001, 16'h1F90, 4'd0,  1, 4'd0,  ST_FULL);
    add_row(FN_FIND, 32'hFFFF_FFFF, 16'hFFFF, 4'd0,  1, 4'd1,  ST_FOUND);
    add_row(FN_FREE, 32'h0,         16'h0,    4'd15, 1, 4'd15, ST_FREED);
    add_row(FN_FIND, 32'hC0A8_0001, 16'h1F90, 4'd0,  0, 4'd0,  ST_FOUND);

    foreach (dir_rows[i]) issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res, 0);
    drain_results();

    // Random phases: back to back, heavy sender idling, light idling, back to back
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 88 : (ph == 2) ? 24 : 0;
      free_pct = (ph == 0) ? 30 : (ph == 1) ? 20 : (ph == 2) ? 45 : 8;
      new_peer_pool();
      for (n = 0; n < 206; n++) begin
        issue(random_cmd(free_pct), 0, no_expect, idle_pct);
        if ($urandom_range(63) == 0) drain_results();
      end
      drain_results();
    end

    drain_results();
    repeat (ENTRIES_DEF + 4) @(posedge clk);

    $display("Covered %0d commands: %0d hits, %0d inserts, %0d table full,",
             accepted, status_seen[ST_FOUND], status_seen[ST_INSERTED], status_seen[ST_FULL]);
    $display("  %0d frees, %0d frees of unused slots; %0d mismatches",
             status_seen[ST_FREED], status_seen[ST_FREE_UNUSED], mismatches);
    if (mismatches == 0) begin
      $display("peer_address_table test passed");
    end else begin
      $display("peer_address_table test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d results pending", pending_results.size());
    $display("peer_address_table test failed");
    $finish;
  end

endmodule
